// ----- rtl/psb_pkg.sv -----
// psb_pkg: shared constants, codes and controller/datapath link types
// for the priority slot buffer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psb_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

   localparam int ID_W      = 16;
   localparam int SRC_W     = 8;
   localparam int TIME_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int FILL_W    = 5;
   localparam int CAP_W     = 5;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // item kinds
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_BUFFERED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   // register index of active_slots
   localparam logic REG_ACTIVE_SLOTS = 1'b0;

   typedef struct packed {
      logic             load;    // latch the accepted item, reset the best-slot search
      logic             scan;    // examine slot at idx
      logic             commit;  // apply the update and post the result
      logic [IDX_W-1:0] idx;
   } psb_cmd_type;

   typedef struct packed {
      logic last;      // idx is the last slot within the capacity
      logic out_busy;  // result register still holds an untaken item
   } psb_stat_type;

endpackage

`default_nettype wire

// ----- rtl/psb_ctrl.sv -----
// psb_ctrl: sequencer for the slot buffer; steps the slot index across
// the active capacity. Depends on psb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psb_ctrl
   import psb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire psb_stat_type stat,
   output psb_cmd_type       cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      cmd.idx    = idx_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.last) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            // hold until the result register is free
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/psb_datapath.sv -----
// psb_datapath: slot storage, best-slot search registers, occupancy,
// capacity register and result register. Depends on psb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psb_datapath
   import psb_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire psb_cmd_type         cmd,
   output psb_stat_type             stat,
   input  wire logic                req_mode,
   input  wire logic [ID_W-1:0]     req_id,
   input  wire logic [SRC_W-1:0]    req_source_num,
   input  wire logic [TIME_W-1:0]   req_gen_time,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ID_W-1:0]          rsp_out_id,
   output logic [SRC_W-1:0]         rsp_out_source,
   output logic [TIME_W-1:0]        rsp_out_time,
   output logic [FILL_W-1:0]        rsp_fill_level,
   input  wire logic                cfg_wr,
   input  wire logic [CAP_W-1:0]    cfg_wdata,
   output logic [CAP_W-1:0]         cfg_cap
);

   // capacity register
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] eff_cap;

   // slot storage
   logic [MAX_SLOTS-1:0] used_ff, used_in;
   logic [ID_W-1:0]      slot_id_ff   [MAX_SLOTS];
   logic [SRC_W-1:0]     slot_src_ff  [MAX_SLOTS];
   logic [TIME_W-1:0]    slot_time_ff [MAX_SLOTS];
   logic [CNT_W-1:0]     occ_ff, occ_in;
   logic                 slot_wr;

   // latched item
   logic                 mode_ff;
   logic [ID_W-1:0]      id_ff;
   logic [SRC_W-1:0]     src_ff;
   logic [TIME_W-1:0]    time_ff;

   // search state
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_ff, best_in;
   logic [ID_W-1:0]      best_id_ff, best_id_in;
   logic [SRC_W-1:0]     best_src_ff, best_src_in;
   logic [TIME_W-1:0]    best_time_ff, best_time_in;

   // result register
   logic                 rv_ff, rv_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [ID_W-1:0]      oid_ff, oid_in;
   logic [SRC_W-1:0]     osrc_ff, osrc_in;
   logic [TIME_W-1:0]    otime_ff, otime_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;

   logic                 rd_used;
   logic [SRC_W-1:0]     rd_src;
   logic [TIME_W-1:0]    rd_time;
   logic                 better;
   logic                 full;

   // saturate the configured capacity to 1..MAX_SLOTS
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (CNT_W'(cap_ff) > CNT_W'(MAX_SLOTS) ||
                   32'(cap_ff) > 32'(MAX_SLOTS)) begin
         eff_cap = CNT_W'(MAX_SLOTS);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign cfg_cap       = cap_ff;
   assign stat.last     = (CNT_W'(cmd.idx) == eff_cap - CNT_W'(1));
   assign stat.out_busy = rv_ff && !rsp_ready;
   assign full          = (occ_ff >= eff_cap);

   assign rd_used = used_ff[cmd.idx];
   assign rd_src  = slot_src_ff[cmd.idx];
   assign rd_time = slot_time_ff[cmd.idx];

   assign better = !found_ff || (rd_src < best_src_ff) ||
                   ((rd_src == best_src_ff) && (rd_time < best_time_ff));

   // search: lowest free slot on push, best occupied slot on pop
   always_comb begin
      found_in     = found_ff;
      best_in      = best_ff;
      best_id_in   = best_id_ff;
      best_src_in  = best_src_ff;
      best_time_in = best_time_ff;
      if (cmd.load) begin
         found_in = 1'b0;
         best_in  = '0;
      end else if (cmd.scan) begin
         if (mode_ff == MODE_PUSH) begin
            if (!rd_used && !found_ff) begin
               found_in = 1'b1;
               best_in  = cmd.idx;
            end
         end else if (rd_used && better) begin
            found_in     = 1'b1;
            best_in      = cmd.idx;
            best_id_in   = slot_id_ff[cmd.idx];
            best_src_in  = rd_src;
            best_time_in = rd_time;
         end
      end
   end

   // commit: slot update, occupancy and result
   always_comb begin
      used_in   = used_ff;
      occ_in    = occ_ff;
      cap_in    = cap_ff;
      slot_wr   = 1'b0;
      rv_in     = rsp_ready ? 1'b0 : rv_ff;
      status_in = status_ff;
      oid_in    = oid_ff;
      osrc_in   = osrc_ff;
      otime_in  = otime_ff;
      fill_in   = fill_ff;
      if (cmd.commit) begin
         rv_in    = 1'b1;
         oid_in   = '0;
         osrc_in  = '0;
         otime_in = '0;
         if (mode_ff == MODE_PUSH) begin
            if (full) begin
               status_in = ST_REJECTED;
               oid_in    = id_ff;
               osrc_in   = src_ff;
               otime_in  = time_ff;
            end else begin
               status_in        = ST_BUFFERED;
               slot_wr          = 1'b1;
               used_in[best_ff] = 1'b1;
               occ_in           = occ_ff + CNT_W'(1);
            end
         end else begin
            if (!found_ff) begin
               status_in = ST_EMPTY;
            end else begin
               status_in        = ST_POPPED;
               oid_in           = best_id_ff;
               osrc_in          = best_src_ff;
               otime_in         = best_time_ff;
               used_in[best_ff] = 1'b0;
               if (occ_ff != '0) begin
                  occ_in = occ_ff - CNT_W'(1);
               end
            end
         end
         fill_in = occ_in;
      end
      // capacity write empties the buffer
      if (cfg_wr) begin
         cap_in  = cfg_wdata;
         used_in = '0;
         occ_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         used_ff  <= '0;
         occ_ff   <= '0;
         rv_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         cap_ff   <= cap_in;
         used_ff  <= used_in;
         occ_ff   <= occ_in;
         rv_ff    <= rv_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         id_ff   <= req_id;
         src_ff  <= req_source_num;
         time_ff <= req_gen_time;
      end
      best_ff      <= best_in;
      best_id_ff   <= best_id_in;
      best_src_ff  <= best_src_in;
      best_time_ff <= best_time_in;
      status_ff    <= status_in;
      oid_ff       <= oid_in;
      osrc_ff      <= osrc_in;
      otime_ff     <= otime_in;
      fill_ff      <= fill_in;
      if (slot_wr) begin
         slot_id_ff[best_ff]   <= id_ff;
         slot_src_ff[best_ff]  <= src_ff;
         slot_time_ff[best_ff] <= time_ff;
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_id     = oid_ff;
   assign rsp_out_source = osrc_ff;
   assign rsp_out_time   = otime_ff;
   assign rsp_fill_level = FILL_W'(fill_ff);

endmodule

`default_nettype wire

// ----- rtl/priority_slot_buffer.sv -----
// priority_slot_buffer: top level; CSR port, sequencer and datapath.
// Depends on psb_pkg, psb_ctrl and psb_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Fixed-slot request buffer. A push item (req_mode = 0) stores its request
// in the lowest free slot and returns status BUFFERED, or, if the buffer
// holds as many requests as the capacity allows, returns status REJECTED
// with the request handed back. A pop item (req_mode = 1) removes and
// returns the request with the lowest source number; ties go to the
// earliest timestamp, then the lowest slot. A pop on an empty buffer returns
// status EMPTY. Every item yields exactly one result, which carries the
// fill level after the item. Each item is latched at the accepting edge;
// the sequencer then walks a single slot read port across the active
// slots, and then commits. It then returns to idle before it takes the
// next item. One item is in work at a time; a new item is taken while
// the previous result still waits in the output register, and its
// commit waits until that result is taken. The only register,
// active_slots at byte address 0, sets the capacity (0 acts as 1, values
// above 16 act as 16; reset value 16). Writing it empties the buffer;
// write it only while no item is in work.

module priority_slot_buffer
   import psb_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_mode,
   input  wire logic [ID_W-1:0]     req_id,
   input  wire logic [SRC_W-1:0]    req_source_num,
   input  wire logic [TIME_W-1:0]   req_gen_time,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ID_W-1:0]          rsp_out_id,
   output logic [SRC_W-1:0]         rsp_out_source,
   output logic [TIME_W-1:0]        rsp_out_time,
   output logic [FILL_W-1:0]        rsp_fill_level,
   // register port
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [ADDR_W-1:0]   csr_paddr,
   input  wire logic [DATA_W-1:0]   csr_pwdata,
   output logic [DATA_W-1:0]        csr_prdata,
   output logic                     csr_pready
);

   psb_cmd_type      cmd;
   psb_stat_type     stat;
   logic             cfg_wr;
   logic [CAP_W-1:0] cfg_cap;
   logic             reg_hit;

   // word index 0 is active_slots; anything else reads zero, ignores writes
   assign reg_hit    = (csr_paddr[ADDR_W-1] == REG_ACTIVE_SLOTS);
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit;
   assign csr_prdata = reg_hit ? DATA_W'(cfg_cap) : '0;

   psb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   psb_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_mode),
      .req_id         (req_id),
      .req_source_num (req_source_num),
      .req_gen_time   (req_gen_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_id     (rsp_out_id),
      .rsp_out_source (rsp_out_source),
      .rsp_out_time   (rsp_out_time),
      .rsp_fill_level (rsp_fill_level),
      .cfg_wr         (cfg_wr),
      .cfg_wdata      (csr_pwdata[CAP_W-1:0]),
      .cfg_cap        (cfg_cap)
   );

endmodule

`default_nettype wire
